### rtl/klpe_pkg.sv
// ----------------------------------------------------------------------------
// klpe_pkg
// Shared types, constants and helpers of the keyed LSB pixel embedder.
// ----------------------------------------------------------------------------
package klpe_pkg;

   localparam int KEY_DEPTH_DEF = 64;

   localparam int DATA_W      = 8;
   localparam int CHAN_N      = 9;
   localparam int SLOT_W      = 4;
   localparam int KLEN_W      = 7;
   localparam int REQ_TDATA_W = DATA_W * (CHAN_N + 1);
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = DATA_W * (CHAN_N + 1);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] OP_LOAD_KEY = 2'd0;
   localparam logic [1:0] OP_EMBED    = 2'd1;
   localparam logic [1:0] OP_EXTRACT  = 2'd2;

   localparam logic [0:0] REG_KEY_LENGTH  = 1'd0;
   localparam logic [0:0] REG_HEADER_MODE = 1'd1;

   localparam logic [SLOT_W-1:0] FETCH_LAST = SLOT_W'(CHAN_N - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_FINISH
   } klpe_state_type;

   typedef struct packed {
      logic load;
      logic key_rd;
      logic use_skip;
      logic use_slot;
      logic finish;
   } klpe_cmd_type;

   typedef struct packed {
      logic out_free;
   } klpe_status_type;

   // v mod 9 for a byte: quotient by reciprocal 57/512, exact over 0..255
   function automatic logic [SLOT_W-1:0] klpe_mod9(input logic [7:0] v);
      logic [13:0] prod;
      logic [4:0]  quo;
      logic [7:0]  rem;
      prod = 14'(v) * 14'd57;
      quo  = prod[13:9];
      rem  = v - 8'({3'b000, quo} * 8'd9);
      return rem[SLOT_W-1:0];
   endfunction

endpackage

### rtl/keyed_lsb_pixel_embedder_core.sv
// ----------------------------------------------------------------------------
// keyed_lsb_pixel_embedder_core
// Hides or recovers one byte in the low bits of three RGB pixels under a key.
// ----------------------------------------------------------------------------
//  port group | direction | contents
//  req_*      | in        | one item: operation, restart, message byte, nine channels
//  rsp_*      | out       | one item: nine channels, recovered byte, end of text
//  csr_*      | in/out    | APB registers: key_length (0x0), header_mode (0x4)
//
//  Embed and extract pass through fetch, drain and finish before the next
//  accept: the key memory has one read port and each byte needs nine reads in turn.
//  Key load and unused operations go from accept straight to finish.
//  A finished item waits in the result register; the next item is accepted
//  meanwhile and stalls only at hand-off if the result is still not taken.
//  Reset clears pointers, FSM, CSRs and rsp_tvalid; key bytes undefined until loaded.
// ----------------------------------------------------------------------------
module keyed_lsb_pixel_embedder_core #(
   parameter int KEY_DEPTH = klpe_pkg::KEY_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // data_byte, chan0 .. chan8
   input  logic [klpe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // operation, restart
   input  logic [klpe_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out0 .. out8, recovered_byte
   output logic [klpe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [klpe_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [klpe_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [klpe_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   klpe_pkg::klpe_cmd_type            cmd;
   klpe_pkg::klpe_status_type         status;
   logic [klpe_pkg::KLEN_W-1:0]       key_length;
   logic                              header_mode;

   klpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_length  (key_length),
      .header_mode (header_mode)
   );

   klpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[1:0]),
      .status     (status),
      .cmd        (cmd)
   );

   klpe_dp #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .key_length  (key_length),
      .header_mode (header_mode),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous item still in work");

   a_keyed_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_tuser[1:0] == klpe_pkg::OP_EMBED || req_tuser[1:0] == klpe_pkg::OP_EXTRACT))
      |-> ##10 !req_tready)
      else $error("keyed item finished before all key reads");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   a_eot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[klpe_pkg::RSP_TDATA_W-1 -: 8] == 8'd0))
      else $error("end of text flagged on non-zero byte");

endmodule

### rtl/klpe_csr.sv
// ----------------------------------------------------------------------------
// klpe_csr
// APB register file: key length and header mode.
// ----------------------------------------------------------------------------
module klpe_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [klpe_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [klpe_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [klpe_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic [klpe_pkg::KLEN_W-1:0]          key_length,
   output logic                                 header_mode
);

   logic [klpe_pkg::KLEN_W-1:0] key_length_ff, key_length_in;
   logic                        header_mode_ff, header_mode_in;
   logic                        wr_en;
   logic [0:0]                  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      key_length_in  = key_length_ff;
      header_mode_in = header_mode_ff;
      if (wr_en) begin
         unique case (reg_idx)
            klpe_pkg::REG_KEY_LENGTH:  key_length_in  = csr_pwdata[klpe_pkg::KLEN_W-1:0];
            klpe_pkg::REG_HEADER_MODE: header_mode_in = csr_pwdata[0];
            default:                   key_length_in  = key_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff  <= klpe_pkg::KLEN_W'(1);
         header_mode_ff <= 1'b0;
      end else begin
         key_length_ff  <= key_length_in;
         header_mode_ff <= header_mode_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         klpe_pkg::REG_KEY_LENGTH:
            csr_prdata = klpe_pkg::CSR_DATA_W'(key_length_ff);
         klpe_pkg::REG_HEADER_MODE:
            csr_prdata = klpe_pkg::CSR_DATA_W'(header_mode_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign key_length  = key_length_ff;
   assign header_mode = header_mode_ff;

endmodule

### rtl/klpe_ctrl.sv
// ----------------------------------------------------------------------------
// klpe_ctrl
// Sequencer: accepts an item, walks the nine key reads, hands off the result.
// ----------------------------------------------------------------------------
module klpe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [1:0]                req_op,
   input  klpe_pkg::klpe_status_type status,
   output klpe_pkg::klpe_cmd_type    cmd
);

   klpe_pkg::klpe_state_type         state_ff, state_in;
   logic [klpe_pkg::SLOT_W-1:0]      cnt_ff, cnt_in;
   logic                             keyed_op;

   assign keyed_op = (req_op == klpe_pkg::OP_EMBED) || (req_op == klpe_pkg::OP_EXTRACT);

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         klpe_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = keyed_op ? klpe_pkg::ST_FETCH : klpe_pkg::ST_FINISH;
            end
         end
         klpe_pkg::ST_FETCH: begin
            cnt_in = cnt_ff + klpe_pkg::SLOT_W'(1);
            if (cnt_ff == klpe_pkg::FETCH_LAST) begin
               state_in = klpe_pkg::ST_DRAIN;
            end
         end
         klpe_pkg::ST_DRAIN: begin
            state_in = klpe_pkg::ST_FINISH;
         end
         klpe_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = klpe_pkg::ST_IDLE;
            end
         end
         default: state_in = klpe_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         klpe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         klpe_pkg::ST_FETCH: begin
            cmd.key_rd   = 1'b1;
            cmd.use_skip = (cnt_ff == klpe_pkg::SLOT_W'(1));
            cmd.use_slot = (cnt_ff > klpe_pkg::SLOT_W'(1));
         end
         klpe_pkg::ST_DRAIN: begin
            cmd.use_slot = 1'b1;
         end
         klpe_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= klpe_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/klpe_dp.sv
// ----------------------------------------------------------------------------
// klpe_dp
// Datapath: key memory and pointers, channel work registers, result register.
// ----------------------------------------------------------------------------
module klpe_dp #(
   parameter int KEY_DEPTH = klpe_pkg::KEY_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  klpe_pkg::klpe_cmd_type               cmd,
   output klpe_pkg::klpe_status_type            status,
   input  logic [klpe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [klpe_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic [klpe_pkg::KLEN_W-1:0]          key_length,
   input  logic                                 header_mode,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [klpe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);

   localparam int PTR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int LEN_W = $clog2(KEY_DEPTH + 1);
   localparam int CMP_W = (LEN_W > klpe_pkg::KLEN_W) ? LEN_W : klpe_pkg::KLEN_W;
   localparam int DW    = klpe_pkg::DATA_W;
   localparam int CN    = klpe_pkg::CHAN_N;
   localparam int SW    = klpe_pkg::SLOT_W;

   logic [DW-1:0]    key_mem [KEY_DEPTH];

   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [DW-1:0]    rd_data_ff;
   logic [1:0]       op_ff, op_in;
   logic [DW-1:0]    msg_ff, msg_in;
   logic [DW-1:0]    rec_ff, rec_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [SW-1:0]    skip_ff, skip_in;
   logic [DW-1:0]    ch_ff [CN];
   logic [DW-1:0]    ch_in [CN];

   logic             out_valid_ff, out_valid_in;
   logic [DW-1:0]    out_ch_ff [CN];
   logic [DW-1:0]    out_rec_ff, out_rec_in;
   logic             out_eot_ff, out_eot_in;

   logic [CMP_W-1:0] eff_len;
   logic [CMP_W-1:0] klen_c;
   logic [PTR_W-1:0] rd_addr, rd_next;
   logic [PTR_W-1:0] wr_addr, wr_next;
   logic [1:0]       req_op;
   logic             req_restart;
   logic [SW-1:0]    eff_slot;
   logic             bit_sel;
   logic             ext_bit;

   assign req_op      = req_tuser[1:0];
   assign req_restart = req_tuser[2];

   // effective key length: zero counts as one, capped at the store depth
   assign klen_c = CMP_W'(key_length);
   always_comb begin
      priority if (klen_c == '0) begin
         eff_len = CMP_W'(1);
      end else if (klen_c > CMP_W'(KEY_DEPTH)) begin
         eff_len = CMP_W'(KEY_DEPTH);
      end else begin
         eff_len = klen_c;
      end
   end

   assign rd_addr = (CMP_W'(rd_pos_ff) >= eff_len) ? '0 : rd_pos_ff;
   assign rd_next = ((CMP_W'(rd_addr) + CMP_W'(1)) >= eff_len) ? '0
                    : PTR_W'(rd_addr + PTR_W'(1));
   assign wr_addr = req_restart ? '0 : wr_pos_ff;
   assign wr_next = ((CMP_W'(wr_addr) + CMP_W'(1)) >= CMP_W'(KEY_DEPTH)) ? '0
                    : PTR_W'(wr_addr + PTR_W'(1));

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && (req_op == klpe_pkg::OP_LOAD_KEY)) begin
         key_mem[wr_addr] <= req_tdata[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_rd) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   assign eff_slot = (slot_ff == skip_ff) ? (slot_ff + SW'(1)) : slot_ff;
   assign bit_sel  = rd_data_ff[0];
   assign ext_bit  = ch_ff[eff_slot][bit_sel];

   always_comb begin
      rd_pos_in = rd_pos_ff;
      wr_pos_in = wr_pos_ff;
      op_in     = op_ff;
      msg_in    = msg_ff;
      rec_in    = rec_ff;
      slot_in   = slot_ff;
      skip_in   = skip_ff;
      for (int i = 0; i < CN; i++) begin
         ch_in[i] = ch_ff[i];
      end

      if (cmd.load) begin
         op_in  = req_op;
         msg_in = req_tdata[DW-1:0];
         rec_in = '0;
         for (int i = 0; i < CN; i++) begin
            ch_in[i] = req_tdata[DW*(i+1) +: DW];
         end
         if (req_op == klpe_pkg::OP_LOAD_KEY) begin
            wr_pos_in = wr_next;
         end else if ((req_op == klpe_pkg::OP_EMBED || req_op == klpe_pkg::OP_EXTRACT)
                      && req_restart) begin
            rd_pos_in = '0;
         end
      end

      if (cmd.key_rd) begin
         rd_pos_in = rd_next;
      end

      if (cmd.use_skip) begin
         skip_in = header_mode ? SW'(rd_data_ff[2:0]) : klpe_pkg::klpe_mod9(rd_data_ff);
         slot_in = '0;
      end

      if (cmd.use_slot) begin
         slot_in = eff_slot + SW'(1);
         msg_in  = {1'b0, msg_ff[DW-1:1]};
         rec_in  = {ext_bit, rec_ff[DW-1:1]};
         if (op_ff == klpe_pkg::OP_EMBED) begin
            for (int i = 0; i < CN; i++) begin
               if (eff_slot == SW'(i)) begin
                  ch_in[i][bit_sel] = msg_ff[0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff <= '0;
         wr_pos_ff <= '0;
      end else begin
         rd_pos_ff <= rd_pos_in;
         wr_pos_ff <= wr_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      msg_ff  <= msg_in;
      rec_ff  <= rec_in;
      slot_ff <= slot_in;
      skip_ff <= skip_in;
      for (int i = 0; i < CN; i++) begin
         ch_ff[i] <= ch_in[i];
      end
   end

   // result register
   assign status.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rec_in   = out_rec_ff;
      out_eot_in   = out_eot_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_rec_in   = (op_ff == klpe_pkg::OP_EXTRACT) ? rec_ff : '0;
         out_eot_in   = (op_ff == klpe_pkg::OP_EXTRACT) && (rec_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff <= out_rec_in;
      out_eot_ff <= out_eot_in;
      for (int i = 0; i < CN; i++) begin
         if (cmd.finish) begin
            out_ch_ff[i] <= ch_ff[i];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_eot_ff;

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < CN; i++) begin
         rsp_tdata[DW*i +: DW] = out_ch_ff[i];
      end
      rsp_tdata[DW*CN +: DW] = out_rec_ff;
   end

endmodule
